>>> design/cdq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the circular deque.
// No dependencies; used by every module of the block.
package cdq_pkg;

    localparam int CDQ_DEPTH = 8;
    localparam int CDQ_WORD_W = 32;

    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_REAR   = 3'd3;
    localparam logic [2:0] KIND_TRAVERSE   = 3'd4;
    localparam logic [2:0] KIND_SEARCH     = 3'd5;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK
    } t_state;

endpackage

>>> design/circular_deque.sv
`timescale 1ns / 1ps
// Circular deque top level: sequencer plus single-port-read word store.
// Depends on cdq_pkg, cdq_mem and cdq_ctrl.
//
// An item is taken when i_start is high and o_busy is low. Every result appears
// for exactly one cycle with o_valid high and must be captured then; o_last marks
// the final result of an item. A push keeps o_busy low, so pushes can follow
// back to back; its result shows the cycle after it is taken. A pop reads its
// word from the store and returns it; traverse returns one word per cycle from
// front to rear, search stops at the first match or at the rear, and any request
// on an empty deque or a full-deque push gives one status result from idle. The
// store's single read port, whose read data is registered, sets these steps.
// Kinds 6 and 7 are ignored and give no result.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = CDQ_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [2:0]                   i_kind,
    input  logic signed [CDQ_WORD_W-1:0] i_value,
    output logic                         o_busy,
    output logic                         o_valid,
    output logic [2:0]                   o_status,
    output logic signed [CDQ_WORD_W-1:0] o_data,
    output logic                         o_last
);

    localparam int AW = $clog2(DEPTH);

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic signed [CDQ_WORD_W-1:0] mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic signed [CDQ_WORD_W-1:0] mem_rdata;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_busy      (o_busy),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_last      (o_last),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    cdq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

>>> design/cdq_mem.sv
`timescale 1ns / 1ps
// Word store of the deque: one write port, one read port, registered read data.
// Depends on cdq_pkg for the word width.
module cdq_mem
    import cdq_pkg::*;
#(
    parameter int DEPTH = CDQ_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic signed [CDQ_WORD_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic signed [CDQ_WORD_W-1:0] o_rdata
);

    logic signed [CDQ_WORD_W-1:0] r_mem [DEPTH];
    logic signed [CDQ_WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/cdq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the deque: front/rear indices, empty flag, walk pointer, results.
// Depends on cdq_pkg; drives the ports of cdq_mem.
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = CDQ_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [2:0]                   i_kind,
    input  logic signed [CDQ_WORD_W-1:0] i_value,
    output logic                         o_busy,
    output logic                         o_valid,
    output logic [2:0]                   o_status,
    output logic signed [CDQ_WORD_W-1:0] o_data,
    output logic                         o_last,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output logic signed [CDQ_WORD_W-1:0] o_mem_wdata,
    output logic                         o_mem_re,
    output logic [AW-1:0]                o_mem_raddr,
    input  logic signed [CDQ_WORD_W-1:0] i_mem_rdata
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    t_state                       r_state, n_state;
    logic [AW-1:0]                r_head, n_head;
    logic [AW-1:0]                r_tail, n_tail;
    logic                         r_empty, n_empty;
    logic [AW-1:0]                r_ptr, n_ptr;
    logic                         r_search, n_search;
    logic signed [CDQ_WORD_W-1:0] r_key, n_key;
    logic                         r_out_valid, n_out_valid;
    t_status                      r_out_status, n_out_status;
    logic signed [CDQ_WORD_W-1:0] r_out_data, n_out_data;
    logic                         r_out_last, n_out_last;

    logic accept;
    logic full;
    logic walk_last;
    logic hit;

    assign accept    = i_start && (r_state == S_IDLE);
    assign full      = !r_empty && (next_idx(r_tail) == r_head);
    assign walk_last = (r_ptr == r_tail);
    assign hit       = (i_mem_rdata == r_key);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !r_empty) begin
                    case (i_kind) inside
                        KIND_POP_FRONT, KIND_POP_REAR: n_state = S_POP;
                        KIND_TRAVERSE, KIND_SEARCH:    n_state = S_WALK;
                        default:                       n_state = S_IDLE;
                    endcase
                end
            end
            S_POP: n_state = S_IDLE;
            S_WALK: begin
                if (walk_last || (r_search && hit)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_ptr        = r_ptr;
        n_search     = r_search;
        n_key        = r_key;
        n_out_valid  = 1'b0;
        n_out_status = ST_OK;
        n_out_data   = '0;
        n_out_last   = 1'b1;
        o_mem_we     = 1'b0;
        o_mem_waddr  = '0;
        o_mem_wdata  = i_value;
        o_mem_re     = 1'b0;
        o_mem_raddr  = r_head;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_out_status = ST_OVERFLOW;
                            end else if (r_empty) begin
                                n_head   = '0;
                                n_tail   = '0;
                                n_empty  = 1'b0;
                                o_mem_we = 1'b1;
                            end else if (i_kind == KIND_PUSH_FRONT) begin
                                n_head      = prev_idx(r_head);
                                o_mem_we    = 1'b1;
                                o_mem_waddr = prev_idx(r_head);
                            end else begin
                                n_tail      = next_idx(r_tail);
                                o_mem_we    = 1'b1;
                                o_mem_waddr = next_idx(r_tail);
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_REAR: begin
                            if (r_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_UNDERFLOW;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = (i_kind == KIND_POP_FRONT) ? r_head : r_tail;
                                if (r_head == r_tail) begin
                                    n_empty = 1'b1;
                                    n_head  = '0;
                                    n_tail  = '0;
                                end else if (i_kind == KIND_POP_FRONT) begin
                                    n_head = next_idx(r_head);
                                end else begin
                                    n_tail = prev_idx(r_tail);
                                end
                            end
                        end
                        KIND_TRAVERSE, KIND_SEARCH: begin
                            if (r_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = r_head;
                                n_ptr       = r_head;
                                n_search    = (i_kind == KIND_SEARCH);
                                n_key       = i_value;
                            end
                        end
                        default: begin
                            // unknown kind: drop the item
                        end
                    endcase
                end
            end
            S_POP: begin
                n_out_valid = 1'b1;
                n_out_data  = i_mem_rdata;
            end
            S_WALK: begin
                if (!r_search) begin
                    n_out_valid = 1'b1;
                    n_out_data  = i_mem_rdata;
                    n_out_last  = walk_last;
                end else if (hit) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_FOUND;
                end else if (walk_last) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_NOT_FOUND;
                end
                // advance to the next occupied entry
                if (!walk_last && !(r_search && hit)) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = next_idx(r_ptr);
                    n_ptr       = next_idx(r_ptr);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_ptr       <= '0;
            r_search    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_ptr       <= n_ptr;
            r_search    <= n_search;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_data   = r_out_data;
    assign o_last   = r_out_last;

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_out_valid && r_out_last && r_out_status == ST_OK))
        else $error("pop did not deliver its word");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0 && r_tail == '0))
        else $error("empty deque with nonzero indices");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= LAST_IDX && r_tail <= LAST_IDX && r_ptr <= LAST_IDX))
        else $error("index beyond store depth");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == KIND_PUSH_FRONT || i_kind == KIND_PUSH_REAR)) |=> !r_empty)
        else $error("push left the deque empty");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_POP) |-> ($past(r_state) != S_IDLE || !$past(r_empty)))
        else $error("walk or pop started on an empty deque");

endmodule
